// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the palette quantizer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define NPQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define NPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/npq_pkg.sv -----
// Package: types, palette table and distance helpers for the palette quantizer.
`timescale 1ns / 1ps
package npq_pkg;

  localparam int unsigned ColorW   = 8;
  localparam int unsigned IdxW     = 4;
  localparam int unsigned SqW      = 2 * ColorW;
  localparam int unsigned DistW    = 18;
  localparam int unsigned NumCells = 16;

  localparam logic [DistW-1:0] MaxDist = DistW'(195075);

  localparam logic [ColorW-1:0] LevelFull = 8'd255;
  localparam logic [ColorW-1:0] LevelHalf = 8'd128;
  localparam logic [ColorW-1:0] GreyLight = 8'd192;
  localparam logic [ColorW-1:0] GreyMid   = 8'd128;

  localparam logic [IdxW-1:0] IdxGreyLight = 4'd7;
  localparam logic [IdxW-1:0] IdxGreyMid   = 4'd8;

  typedef struct packed {
    logic [ColorW-1:0] red;
    logic [ColorW-1:0] green;
    logic [ColorW-1:0] blue;
  } rgb_t;

  // Data handed from one cell to the next.
  typedef struct packed {
    rgb_t             pix;
    logic [IdxW-1:0]  idx;
    logic [DistW-1:0] dist_sq;
  } stage_t;

  function automatic rgb_t palette_color(logic [IdxW-1:0] idx);
    rgb_t              c;
    logic [ColorW-1:0] lvl;
    lvl = idx[3] ? LevelFull : LevelHalf;
    c.red   = idx[0] ? lvl : '0;
    c.green = idx[1] ? lvl : '0;
    c.blue  = idx[2] ? lvl : '0;
    case (idx)
      IdxGreyLight: c = '{red: GreyLight, green: GreyLight, blue: GreyLight};
      IdxGreyMid:   c = '{red: GreyMid, green: GreyMid, blue: GreyMid};
      default:      ;
    endcase
    return c;
  endfunction

  function automatic logic [SqW-1:0] sq_diff(logic [ColorW-1:0] a, logic [ColorW-1:0] b);
    logic [ColorW-1:0] d;
    d = (a > b) ? (a - b) : (b - a);
    return SqW'(d) * SqW'(d);
  endfunction

endpackage

// ----- hw/rtl/npq_pix_if.sv -----
// Pixel request channel: valid/ready handshake with an RGB payload.
`timescale 1ns / 1ps
interface npq_pix_if;
  import npq_pkg::*;

  logic              valid;
  logic              ready;
  logic [ColorW-1:0] red;
  logic [ColorW-1:0] green;
  logic [ColorW-1:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

// ----- hw/rtl/npq_res_if.sv -----
// Result request channel: chosen palette entry, its color and distance.
`timescale 1ns / 1ps
interface npq_res_if;
  import npq_pkg::*;

  logic              valid;
  logic              ready;
  logic [IdxW-1:0]   palette_index;
  logic [ColorW-1:0] shown_red;
  logic [ColorW-1:0] shown_green;
  logic [ColorW-1:0] shown_blue;
  logic [DistW-1:0]  best_distance;

  modport source (output valid, output palette_index, output shown_red,
                  output shown_green, output shown_blue, output best_distance,
                  input ready);
  modport sink   (input valid, input palette_index, input shown_red,
                  input shown_green, input shown_blue, input best_distance,
                  output ready);
endinterface

// ----- hw/rtl/npq_cell.sv -----
// One cell of the chain: scores one palette entry and keeps the running best.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module npq_cell import npq_pkg::*; #(
  parameter logic [IdxW-1:0] CellIdx = '0
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   in_valid_i,
  output logic   in_ready_o,
  input  stage_t in_data_i,
  output logic   out_valid_o,
  input  logic   out_ready_i,
  output stage_t out_data_o
);

  localparam rgb_t Pal = palette_color(CellIdx);

  logic             valid_q, valid_d;
  stage_t           data_q, data_d;
  logic [DistW-1:0] cand_dist;
  logic             take;

  assign in_ready_o = !valid_q || out_ready_i;

  always_comb begin
    cand_dist = DistW'(sq_diff(Pal.red, in_data_i.pix.red))
              + DistW'(sq_diff(Pal.green, in_data_i.pix.green))
              + DistW'(sq_diff(Pal.blue, in_data_i.pix.blue));
    take = (CellIdx == '0) || (cand_dist < in_data_i.dist_sq);
    data_d = in_data_i;
    if (take) begin
      data_d.idx     = CellIdx;
      data_d.dist_sq = cand_dist;
    end
    valid_d = in_ready_o ? in_valid_i : valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  `NPQ_ASSERT_NEXT(a_hold_on_stall, valid_q && !out_ready_i, valid_q && $stable(data_q),
    "cell dropped or changed a stalled request")
  `NPQ_ASSERT(a_idx_in_range, !valid_q || (data_q.idx <= CellIdx),
    "cell holds an index beyond its own position")

endmodule

// ----- hw/rtl/nearest_palette_color_quantizer.sv -----
// Top level: chain of 16 cells, one per palette entry, feeding the result channel.
// Pipeline: 16 register stages, one per cell; the result is offered from the register of the
// last cell.
// Throughput: one pixel per cycle while the result side keeps ready high; each cell holds one
// pixel, and a stalled result backs up the chain one cell at a time, so bubbles are squeezed out.
// Reset: asynchronous, active low; clears the cell valid flags only.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module nearest_palette_color_quantizer import npq_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  npq_pix_if.sink    pix_i,
  npq_res_if.source  res_o
);

  logic   valid [NumCells+1];
  logic   ready [NumCells+1];
  stage_t data  [NumCells+1];
  rgb_t   shown;

  assign valid[0]          = pix_i.valid;
  assign pix_i.ready       = ready[0];
  assign data[0].pix.red   = pix_i.red;
  assign data[0].pix.green = pix_i.green;
  assign data[0].pix.blue  = pix_i.blue;
  assign data[0].idx       = '0;
  assign data[0].dist_sq   = '0;

  for (genvar i = 0; i < NumCells; i++) begin : g_cell
    npq_cell #(
      .CellIdx(IdxW'(i))
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .in_valid_i (valid[i]),
      .in_ready_o (ready[i]),
      .in_data_i  (data[i]),
      .out_valid_o(valid[i+1]),
      .out_ready_i(ready[i+1]),
      .out_data_o (data[i+1])
    );
  end

  assign ready[NumCells] = res_o.ready;
  assign shown           = palette_color(data[NumCells].idx);

  assign res_o.valid         = valid[NumCells];
  assign res_o.palette_index = data[NumCells].idx;
  assign res_o.shown_red     = shown.red;
  assign res_o.shown_green   = shown.green;
  assign res_o.shown_blue    = shown.blue;
  assign res_o.best_distance = data[NumCells].dist_sq;

  `NPQ_ASSERT(a_dist_bound, !res_o.valid || (res_o.best_distance <= MaxDist),
    "result distance above the largest possible value")

endmodule

// ----- bench/nearest_palette_color_quantizer_tb.sv -----
// Testbench for the palette quantizer: a directed table, then random pixels, checked in order.
`timescale 1ns / 1ps
module nearest_palette_color_quantizer_tb;
  import npq_pkg::*;

  localparam int NumDirected = 23;
  localparam int NumRandom   = 1800;
  localparam int MaxIdle     = 17;
  localparam int LongHold    = 300;
  localparam int HoldAfter   = 400;
  localparam int PauseAt     = 900;
  localparam int DrainCycles = 24;
  localparam int CycleLimit  = 400000;

  typedef struct packed {
    logic [IdxW-1:0]  idx;
    rgb_t             shade;
    logic [DistW-1:0] dist_sq;
  } quant_t;

  typedef struct packed {
    rgb_t   px;
    logic   typed;
    quant_t want;
  } pixel_row_t;

  localparam int Boundary [15] = '{63, 64, 65, 95, 96, 97, 127, 128,
                                   159, 160, 161, 191, 192, 223, 224};

  // Typed rows: exact palette hits and ties; the rest go through the predictor.
  pixel_row_t pixel_rows [NumDirected] = '{
    '{'{8'd0,   8'd0,   8'd0  }, 1'b1, '{4'd0,  '{8'd0,   8'd0,   8'd0  }, 18'd0}},
    '{'{8'd128, 8'd0,   8'd0  }, 1'b1, '{4'd1,  '{8'd128, 8'd0,   8'd0  }, 18'd0}},
    '{'{8'd0,   8'd128, 8'd0  }, 1'b1, '{4'd2,  '{8'd0,   8'd128, 8'd0  }, 18'd0}},
    '{'{8'd128, 8'd128, 8'd0  }, 1'b1, '{4'd3,  '{8'd128, 8'd128, 8'd0  }, 18'd0}},
    '{'{8'd0,   8'd0,   8'd128}, 1'b1, '{4'd4,  '{8'd0,   8'd0,   8'd128}, 18'd0}},
    '{'{8'd128, 8'd0,   8'd128}, 1'b1, '{4'd5,  '{8'd128, 8'd0,   8'd128}, 18'd0}},
    '{'{8'd0,   8'd128, 8'd128}, 1'b1, '{4'd6,  '{8'd0,   8'd128, 8'd128}, 18'd0}},
    '{'{8'd192, 8'd192, 8'd192}, 1'b1, '{4'd7,  '{8'd192, 8'd192, 8'd192}, 18'd0}},
    '{'{8'd128, 8'd128, 8'd128}, 1'b1, '{4'd8,  '{8'd128, 8'd128, 8'd128}, 18'd0}},
    '{'{8'd255, 8'd0,   8'd0  }, 1'b1, '{4'd9,  '{8'd255, 8'd0,   8'd0  }, 18'd0}},
    '{'{8'd0,   8'd255, 8'd0  }, 1'b1, '{4'd10, '{8'd0,   8'd255, 8'd0  }, 18'd0}},
    '{'{8'd255, 8'd255, 8'd0  }, 1'b1, '{4'd11, '{8'd255, 8'd255, 8'd0  }, 18'd0}},
    '{'{8'd0,   8'd0,   8'd255}, 1'b1, '{4'd12, '{8'd0,   8'd0,   8'd255}, 18'd0}},
    '{'{8'd255, 8'd0,   8'd255}, 1'b1, '{4'd13, '{8'd255, 8'd0,   8'd255}, 18'd0}},
    '{'{8'd0,   8'd255, 8'd255}, 1'b1, '{4'd14, '{8'd0,   8'd255, 8'd255}, 18'd0}},
    '{'{8'd255, 8'd255, 8'd255}, 1'b1, '{4'd15, '{8'd255, 8'd255, 8'd255}, 18'd0}},
    '{'{8'd64,  8'd0,   8'd0  }, 1'b1, '{4'd0,  '{8'd0,   8'd0,   8'd0  }, 18'd4096}},
    '{'{8'd0,   8'd0,   8'd64 }, 1'b1, '{4'd0,  '{8'd0,   8'd0,   8'd0  }, 18'd4096}},
    '{'{8'd160, 8'd160, 8'd160}, 1'b1, '{4'd7,  '{8'd192, 8'd192, 8'd192}, 18'd3072}},
    '{'{8'd255, 8'd128, 8'd0  }, 1'b0, '0},
    '{'{8'd37,  8'd200, 8'd90 }, 1'b0, '0},
    '{'{8'd128, 8'd255, 8'd64 }, 1'b0, '0},
    '{'{8'd200, 8'd10,  8'd250}, 1'b0, '0}
  };

  logic clk_i;
  logic rst_ni;

  npq_pix_if pix ();
  npq_res_if res ();

  nearest_palette_color_quantizer DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pix_i  (pix),
    .res_o  (res)
  );

  quant_t quantized_q [$];
  int     pixels_sent;
  int     results_checked;
  int     mismatch_count;
  int     cycle_count;
  bit     long_hold_done;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic rgb_t entry_shade(int idx);
    rgb_t c;
    case (idx)
      0:       c = '{8'd0,   8'd0,   8'd0  };
      1:       c = '{8'd128, 8'd0,   8'd0  };
      2:       c = '{8'd0,   8'd128, 8'd0  };
      3:       c = '{8'd128, 8'd128, 8'd0  };
      4:       c = '{8'd0,   8'd0,   8'd128};
      5:       c = '{8'd128, 8'd0,   8'd128};
      6:       c = '{8'd0,   8'd128, 8'd128};
      7:       c = '{8'd192, 8'd192, 8'd192};
      8:       c = '{8'd128, 8'd128, 8'd128};
      9:       c = '{8'd255, 8'd0,   8'd0  };
      10:      c = '{8'd0,   8'd255, 8'd0  };
      11:      c = '{8'd255, 8'd255, 8'd0  };
      12:      c = '{8'd0,   8'd0,   8'd255};
      13:      c = '{8'd255, 8'd0,   8'd255};
      14:      c = '{8'd0,   8'd255, 8'd255};
      default: c = '{8'd255, 8'd255, 8'd255};
    endcase
    return c;
  endfunction

  // Strictly smaller distance replaces, so the lowest index wins a tie.
  function automatic quant_t nearest_entry(rgb_t px);
    quant_t best;
    rgb_t   c;
    int     dr, dg, db, d, best_d;
    best_d = -1;
    best   = '0;
    for (int p = 0; p < 16; p++) begin
      c  = entry_shade(p);
      dr = int'(px.red) - int'(c.red);
      dg = int'(px.green) - int'(c.green);
      db = int'(px.blue) - int'(c.blue);
      d  = dr * dr + dg * dg + db * db;
      if (best_d < 0 || d < best_d) begin
        best_d     = d;
        best.idx   = p[IdxW-1:0];
        best.shade = c;
      end
    end
    best.dist_sq = best_d[DistW-1:0];
    return best;
  endfunction

  function automatic logic [7:0] clamp_level(int v);
    if (v < 0) return 8'd0;
    if (v > 255) return 8'd255;
    return v[7:0];
  endfunction

  // Mix of uniform colors, colors near a palette entry, near-tie points and channel extremes.
  function automatic rgb_t random_pixel();
    rgb_t px;
    rgb_t c;
    int   kind;
    kind = $urandom_range(0, 9);
    if (kind < 4) begin
      px = rgb_t'(24'($urandom));
    end else if (kind < 7) begin
      c = entry_shade($urandom_range(0, 15));
      px.red   = clamp_level(int'(c.red) + $urandom_range(0, 40) - 20);
      px.green = clamp_level(int'(c.green) + $urandom_range(0, 40) - 20);
      px.blue  = clamp_level(int'(c.blue) + $urandom_range(0, 40) - 20);
    end else if (kind < 9) begin
      px.red   = 8'(Boundary[$urandom_range(0, 14)]);
      px.green = 8'(Boundary[$urandom_range(0, 14)]);
      px.blue  = 8'(Boundary[$urandom_range(0, 14)]);
    end else begin
      px.red   = $urandom_range(0, 1) ? 8'd255 : 8'd0;
      px.green = $urandom_range(0, 1) ? 8'd255 : 8'd0;
      px.blue  = $urandom_range(0, 1) ? 8'd255 : 8'd0;
    end
    return px;
  endfunction

  task automatic offer_pixel(input rgb_t px, input int gap, input quant_t want);
    if (gap > 0) begin
      pix.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    pix.valid <= 1'b1;
    pix.red   <= px.red;
    pix.green <= px.green;
    pix.blue  <= px.blue;
    do @(posedge clk_i); while (!pix.ready);
    quantized_q.push_back(want);
    pixels_sent++;
  endtask

  task automatic compare_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk_i) begin
    quant_t want;
    if (rst_ni && res.valid && res.ready) begin
      if (quantized_q.size() == 0) begin
        $display("%0t: result with no pixel pending, index %0d", $time, res.palette_index);
        mismatch_count++;
      end else begin
        want = quantized_q.pop_front();
        compare_field("palette_index", want.idx, res.palette_index);
        compare_field("shown_red", want.shade.red, res.shown_red);
        compare_field("shown_green", want.shade.green, res.shown_green);
        compare_field("shown_blue", want.shade.blue, res.shown_blue);
        compare_field("best_distance", want.dist_sq, res.best_distance);
      end
      results_checked++;
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("%0t: timeout, %0d results pending", $time, quantized_q.size());
      $display("FAIL nearest_palette_color_quantizer");
      $finish;
    end
  end

  // Result side: random stalls, bursts of steady ready, one long hold-off.
  initial begin
    int stall;
    int served;
    bit burst;
    res.ready = 1'b0;
    served    = 0;
    burst     = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (!long_hold_done && results_checked >= HoldAfter) begin
        long_hold_done = 1'b1;
        res.ready <= 1'b0;
        repeat (LongHold) @(posedge clk_i);
      end
      if (served % 80 == 0) burst = ($urandom_range(0, 3) == 0);
      stall = burst ? 0 : $urandom_range(0, MaxIdle);
      if (stall > 0) begin
        res.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      res.ready <= 1'b1;
      do @(posedge clk_i); while (!res.valid);
      served++;
    end
  end

  // Pixel side and run control.
  initial begin
    rgb_t   px;
    quant_t want;
    int     gap;
    bit     burst;
    cycle_count     = 0;
    pixels_sent     = 0;
    results_checked = 0;
    mismatch_count  = 0;
    long_hold_done  = 1'b0;
    burst           = 1'b0;
    pix.valid = 1'b0;
    pix.red   = '0;
    pix.green = '0;
    pix.blue  = '0;
    rst_ni    = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < NumDirected; i++) begin
      px   = pixel_rows[i].px;
      want = pixel_rows[i].typed ? pixel_rows[i].want : nearest_entry(px);
      offer_pixel(px, $urandom_range(0, MaxIdle), want);
    end

    for (int i = 0; i < NumRandom; i++) begin
      if (i == PauseAt) begin
        pix.valid <= 1'b0;
        do @(posedge clk_i); while (quantized_q.size() != 0);
      end
      if (i % 100 == 0) burst = ($urandom_range(0, 2) == 0);
      gap = burst ? 0 : $urandom_range(0, MaxIdle);
      px  = random_pixel();
      offer_pixel(px, gap, nearest_entry(px));
    end

    pix.valid <= 1'b0;
    do @(posedge clk_i); while (quantized_q.size() != 0);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Quantized %0d pixels (%0d table rows, %0d random) with random idling on both sides.",
             pixels_sent, NumDirected, NumRandom);
    $display("Checked %0d results, %0d mismatches, long result hold-off %0s.",
             results_checked, mismatch_count, long_hold_done ? "done" : "not reached");
    if (mismatch_count == 0 && quantized_q.size() == 0) begin
      $display("PASS nearest_palette_color_quantizer");
    end else begin
      $display("FAIL nearest_palette_color_quantizer");
    end
    $finish;
  end

endmodule
